>>> src/upd_pkg.sv
// Shared types, constants and helper functions for the URL percent decoder.
// No dependencies; upd_front, upd_queue, upd_back and the top level import this package.
package upd_pkg;

  localparam logic [7:0] PCT_CHAR = 8'h25;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Escape tracking, one-hot.
  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_PCT   = 3'b010,
    PH_DIGIT = 3'b100
  } phase_t;

  // One classified input byte: up to three output bytes, first in slot 0.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
    logic            last;
  } job_t;

  // Status from the front end.
  typedef struct packed {
    logic push;
    logic pending;
  } front_stat_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  // Letters a-f and A-F have low nibbles 1..6, which map to 10..15.
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    if (c <= 8'h39) begin
      hex_nibble = c[3:0];
    end else begin
      hex_nibble = c[3:0] + 4'd9;
    end
  endfunction

endpackage

>>> src/upd_if.sv
// Handshake interfaces for the raw input bytes and the decoded output bytes.
// No dependencies.
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, in_byte, in_last, input ready);
  modport sink (input valid, in_byte, in_last, output ready);
endinterface

interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_run_last;
  logic       out_text_last;
  modport source (output valid, out_byte, out_run_last, out_text_last, input ready);
  modport sink (input valid, out_byte, out_run_last, out_text_last, output ready);
endinterface

>>> src/upd_front.sv
// Front end: accepts raw bytes, tracks the escape state and turns each byte
// into a job of zero to three output bytes. Depends on upd_pkg and upd_if.
module upd_front (
  input  logic               clk,
  input  logic               rst,
  upd_in_if.sink             rx,
  input  logic               q_full,
  output upd_pkg::job_t      job,
  output upd_pkg::front_stat_t stat
);
  import upd_pkg::*;

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] held;
  logic [7:0] held_next;
  logic       accept;
  logic       b_hex;
  logic       pct_hold;
  logic [7:0] b;

  assign b        = rx.in_byte;
  assign b_hex    = is_hex(b);
  assign pct_hold = (b == PCT_CHAR) && !rx.in_last;
  assign rx.ready = !q_full;
  assign accept   = rx.valid && rx.ready;

  always_comb begin
    job.cnt    = 2'd0;
    job.bytes  = '{b, held, PCT_CHAR};
    job.last   = rx.in_last;
    phase_next = PH_IDLE;
    held_next  = held;
    case (phase)
      PH_PCT: begin
        if (b_hex && !rx.in_last) begin
          phase_next = PH_DIGIT;
          held_next  = b;
        end else if (b_hex || !pct_hold) begin
          job.cnt      = 2'd2;
          job.bytes[1] = b;
        end else begin
          job.cnt    = 2'd1;
          phase_next = PH_PCT;
        end
      end
      PH_DIGIT: begin
        if (b_hex) begin
          job.cnt      = 2'd1;
          job.bytes[0] = {hex_nibble(held), hex_nibble(b)};
        end else if (pct_hold) begin
          // The broken escape flushes, and this '%' opens a new one.
          job.cnt    = 2'd2;
          phase_next = PH_PCT;
        end else begin
          job.cnt = 2'd3;
        end
      end
      default: begin
        if (pct_hold) begin
          phase_next = PH_PCT;
        end else begin
          job.cnt      = 2'd1;
          job.bytes[0] = b;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= held_next;
    end
  end

  assign stat.push    = accept && (job.cnt != 2'd0);
  assign stat.pending = (phase != PH_IDLE);

endmodule

>>> src/upd_queue.sv
// Short first-in first-out queue of jobs between the front and back ends.
// Depends on upd_pkg. DEPTH must be a power of two, at least 2.
module upd_queue #(
  parameter int unsigned DEPTH = upd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  upd_pkg::job_t wr_job,
  input  logic          pop,
  output upd_pkg::job_t head,
  output logic          full,
  output logic          empty
);
  import upd_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  job_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

endmodule

>>> src/upd_back.sv
// Back end: walks the bytes of the job at the queue head, one per cycle
// while tx is not stalled, into the output register. Depends on upd_pkg and upd_if.
module upd_back (
  input  logic          clk,
  input  logic          rst,
  input  upd_pkg::job_t head,
  input  logic          empty,
  output logic          pop,
  upd_out_if.source     tx
);
  import upd_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       at_end;

  assign load   = !tx.valid || tx.ready;
  assign at_end = (idx == head.cnt - 2'd1);
  assign pop    = load && !empty && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      tx.valid <= 1'b0;
      idx      <= 2'd0;
    end else if (load) begin
      tx.valid <= !empty;
      if (!empty) begin
        idx <= at_end ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      tx.out_byte      <= head.bytes[idx];
      tx.out_run_last  <= at_end;
      tx.out_text_last <= at_end && head.last;
    end
  end

endmodule

>>> src/url_percent_decoder_top.sv
// Top level of the streaming URL percent decoder: front end, job queue and
// back end. Depends on upd_pkg, upd_if, upd_front, upd_queue and upd_back.
//
//   channel | dir | payload                                 | item
//   rx      | in  | in_byte[7:0], in_last                   | one raw byte
//   tx      | out | out_byte[7:0], out_run_last, out_text_last | one decoded byte
//
// The front end takes one raw byte per cycle while the job queue has room.
// The back end sends one decoded byte per cycle while tx is ready; a byte
// that yields three results keeps it busy longer, and the queue of QUEUE_DEPTH
// jobs absorbs such bursts. With the queue empty, a decoded byte goes from
// its queue entry through the output register to tx.
// Reset returns the escape state to idle and empties the queue and output.
module url_percent_decoder_top #(
  parameter int unsigned QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  upd_in_if.sink    rx,
  upd_out_if.source tx
);
  import upd_pkg::*;

  job_t        job;
  job_t        head;
  front_stat_t stat;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;

  upd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx),
    .q_full (q_full),
    .job    (job),
    .stat   (stat)
  );

  upd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (stat.push),
    .wr_job (job),
    .pop    (q_pop),
    .head   (head),
    .full   (q_full),
    .empty  (q_empty)
  );

  upd_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (q_empty),
    .pop   (q_pop),
    .tx    (tx)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    stat.push |-> !q_full)
    else $error("job pushed into a full queue");

  a_last_clears_escape: assert property (@(posedge clk) disable iff (rst)
    rx.valid && rx.ready && rx.in_last |=> !stat.pending)
    else $error("escape still pending after end of text");

  a_text_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    tx.valid && tx.out_text_last |-> tx.out_run_last)
    else $error("end of text marked on a byte that does not end its run");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("pop from an empty queue");

endmodule
